FILE: design/view_coordinates_2d_defines.svh
// Assertion macros for the view coordinates block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef VIEW_COORDINATES_2D_DEFINES_SVH
`define VIEW_COORDINATES_2D_DEFINES_SVH

// same-cycle implication
`define VC2D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VC2D_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vc2d_pkg.sv
// Shared types, constants and step functions of the view coordinates block.
// No dependencies.
package vc2d_pkg;

	localparam int FRAC_BITS = 14;
	localparam int OUT_SHIFT = 54 - FRAC_BITS;
	localparam logic [15:0] DEG_Y = (FRAC_BITS >= 15) ? 16'h7fff : 16'(1 << FRAC_BITS);

	localparam int CORDIC_N = 24;
	localparam logic signed [25:0] ATAN_TAB [CORDIC_N] = '{
		26'sd4194304, 26'sd2476042, 26'sd1308273, 26'sd664100, 26'sd333339, 26'sd166832,
		26'sd83436, 26'sd41721, 26'sd20861, 26'sd10430, 26'sd5215, 26'sd2608,
		26'sd1304, 26'sd652, 26'sd326, 26'sd163, 26'sd81, 26'sd41,
		26'sd20, 26'sd10, 26'sd5, 26'sd3, 26'sd1, 26'sd1
	};

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int CNT_W = FIFO_AW + 1;

	typedef struct packed {
		logic [55:0] pp;
		logic [47:0] ee;
		logic signed [45:0] up_p;
		logic signed [41:0] dv;
		logic deg;
		logic sd_pos;
	} fe_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] q;
		logic [63:0] x;
	} sq_step_t;

	typedef struct packed {
		logic [27:0] rem;
		logic [32:0] low;
		logic [32:0] q;
	} dv_step_t;

	// one root bit: take the next two radicand bits
	function automatic sq_step_t sq_step(input sq_step_t a);
		sq_step_t r;
		logic [35:0] t;
		logic [35:0] tr;
		t = {a.rem, a.x[63:62]};
		tr = {2'b00, a.q, 2'b01};
		r.x = {a.x[61:0], 2'b00};
		if (t >= tr) begin
			r.rem = 34'(t - tr);
			r.q = {a.q[30:0], 1'b1};
		end else begin
			r.rem = t[33:0];
			r.q = {a.q[30:0], 1'b0};
		end
		return r;
	endfunction

	// one quotient bit of a restoring divide
	function automatic dv_step_t div_step(input dv_step_t a, input logic [27:0] dsr);
		dv_step_t r;
		logic [28:0] t;
		t = {a.rem, a.low[32]};
		r.low = {a.low[31:0], 1'b0};
		if (t >= {1'b0, dsr}) begin
			r.rem = 28'(t - {1'b0, dsr});
			r.q = {a.q[31:0], 1'b1};
		end else begin
			r.rem = t[27:0];
			r.q = {a.q[31:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: design/vc2d_fifo.sv
// Short word queue between the front and back parts.
// Depends on vc2d_pkg.
module vc2d_fifo import vc2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  fe_item_t   push_item,
	input  logic       pop,
	output fe_item_t   pop_item,
	output fifo_stat_t stat
);

	fe_item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	assign pop_item = mem_q[rd_ptr_q];
	assign stat.full = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

FILE: design/vc2d_front.sv
// Front part: accepts words, normalizes the offset, projects it and sorts out
// the zero-projection case. Depends on vc2d_pkg.
module vc2d_front import vc2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,
	input  fifo_stat_t   fifo_stat,
	output logic         push,
	output fe_item_t     push_item
);

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	logic [9:0] vld_q;
	logic en;

	logic signed [32:0] d_s1 [3];
	logic signed [32:0] d_s2 [3];
	logic signed [32:0] d_s3 [3];
	logic signed [15:0] v_s1 [3];
	logic signed [15:0] v_s2 [3];
	logic signed [15:0] v_s3 [3];
	logic signed [15:0] v_s4 [3];
	logic signed [15:0] v_s5 [3];
	logic signed [15:0] v_s6 [3];
	logic signed [15:0] u_s1 [3];
	logic signed [15:0] u_s2 [3];
	logic signed [15:0] u_s3 [3];
	logic signed [15:0] u_s4 [3];
	logic signed [15:0] u_s5 [3];
	logic signed [15:0] u_s6 [3];
	logic signed [15:0] u_s7 [3];
	logic signed [15:0] u_s8 [3];
	logic [32:0] mag_s2;
	logic [3:0] rs_s3;
	logic [4:0] ls_s3;
	logic signed [23:0] e_s4 [3];
	logic signed [23:0] e_s5 [3];
	logic signed [23:0] e_s6 [3];
	logic signed [23:0] e_s7 [3];
	logic signed [23:0] e_s8 [3];
	logic signed [39:0] pv_s5 [3];
	logic signed [31:0] xa_s5 [3];
	logic signed [31:0] xb_s5 [3];
	logic signed [41:0] dv_s6;
	logic signed [41:0] dv_s7;
	logic signed [41:0] dv_s8;
	logic signed [41:0] dv_s9;
	logic signed [41:0] dv_s10;
	logic signed [32:0] r_s6 [3];
	logic signed [57:0] dvv_s7 [3];
	logic signed [56:0] re_s7 [3];
	logic signed [27:0] p_s8 [3];
	logic sd_pos_s8;
	logic sd_pos_s9;
	logic sd_pos_s10;
	logic [53:0] ppi_s9 [3];
	logic [46:0] eei_s9 [3];
	logic signed [43:0] upi_s9 [3];
	logic pz_s9;
	logic [55:0] pp_s10;
	logic [47:0] ee_s10;
	logic signed [45:0] up_s10;
	logic deg_s10;

	logic [32:0] abs_c [3];
	logic [32:0] mag_c;
	logic [5:0] msb_c;
	logic [3:0] rs_c;
	logic [4:0] ls_c;
	logic signed [57:0] sh_c [3];
	logic signed [58:0] sd_c;

	assign en = !vld_q[9] || !fifo_stat.full;
	assign s_tready = en;
	assign push = vld_q[9] && !fifo_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[8:0], s_tvalid};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			abs_c[i] = d_s1[i][32] ? 33'(-d_s1[i]) : 33'(d_s1[i]);
		mag_c = abs_c[0];
		if (abs_c[1] > mag_c)
			mag_c = abs_c[1];
		if (abs_c[2] > mag_c)
			mag_c = abs_c[2];
		msb_c = '0;
		for (int k = 0; k < 33; k++)
			if (mag_s2[k])
				msb_c = 6'(k);
		rs_c = (msb_c >= 6'd23) ? 4'(msb_c - 6'd22) : 4'd0;
		ls_c = (msb_c < 6'd22) ? 5'(6'd22 - msb_c) : 5'd0;
		for (int i = 0; i < 3; i++)
			sh_c[i] = dvv_s7[i] >>> 28;
		sd_c = 59'(re_s7[0]) + 59'(re_s7[1]) + 59'(re_s7[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= 33'(signed'(s_tdata[192 + i*32 +: 32])) -
					33'(signed'(s_tdata[i*32 +: 32]));
				v_s1[i] <= signed'(s_tdata[96 + i*16 +: 16]);
				u_s1[i] <= signed'(s_tdata[144 + i*16 +: 16]);
				d_s2[i] <= d_s1[i];
				d_s3[i] <= d_s2[i];
				v_s2[i] <= v_s1[i];
				v_s3[i] <= v_s2[i];
				v_s4[i] <= v_s3[i];
				v_s5[i] <= v_s4[i];
				v_s6[i] <= v_s5[i];
				u_s2[i] <= u_s1[i];
				u_s3[i] <= u_s2[i];
				u_s4[i] <= u_s3[i];
				u_s5[i] <= u_s4[i];
				u_s6[i] <= u_s5[i];
				u_s7[i] <= u_s6[i];
				u_s8[i] <= u_s7[i];
				e_s4[i] <= (rs_s3 != 4'd0) ? 24'(d_s3[i] >>> rs_s3) : 24'(d_s3[i] <<< ls_s3);
				e_s5[i] <= e_s4[i];
				e_s6[i] <= e_s5[i];
				e_s7[i] <= e_s6[i];
				e_s8[i] <= e_s7[i];
				pv_s5[i] <= 40'(v_s4[i]) * 40'(e_s4[i]);
				xa_s5[i] <= 32'(v_s4[NXT[i]]) * 32'(u_s4[PRV[i]]);
				xb_s5[i] <= 32'(v_s4[PRV[i]]) * 32'(u_s4[NXT[i]]);
				r_s6[i] <= 33'(xa_s5[i]) - 33'(xb_s5[i]);
				dvv_s7[i] <= 58'(dv_s6) * 58'(v_s6[i]);
				re_s7[i] <= 57'(r_s6[i]) * 57'(e_s6[i]);
				p_s8[i] <= 28'(58'(e_s7[i]) - sh_c[i]);
				ppi_s9[i] <= 54'(56'(p_s8[i]) * 56'(p_s8[i]));
				eei_s9[i] <= 47'(48'(e_s8[i]) * 48'(e_s8[i]));
				upi_s9[i] <= 44'(u_s8[i]) * 44'(p_s8[i]);
			end
			mag_s2 <= mag_c;
			rs_s3 <= rs_c;
			ls_s3 <= ls_c;
			dv_s6 <= 42'(pv_s5[0]) + 42'(pv_s5[1]) + 42'(pv_s5[2]);
			dv_s7 <= dv_s6;
			dv_s8 <= dv_s7;
			dv_s9 <= dv_s8;
			dv_s10 <= dv_s9;
			sd_pos_s8 <= (sd_c > 59'sd0);
			sd_pos_s9 <= sd_pos_s8;
			sd_pos_s10 <= sd_pos_s9;
			pz_s9 <= (p_s8[0] == '0) && (p_s8[1] == '0) && (p_s8[2] == '0);
			pp_s10 <= 56'(ppi_s9[0]) + 56'(ppi_s9[1]) + 56'(ppi_s9[2]);
			ee_s10 <= 48'(eei_s9[0]) + 48'(eei_s9[1]) + 48'(eei_s9[2]);
			up_s10 <= 46'(upi_s9[0]) + 46'(upi_s9[1]) + 46'(upi_s9[2]);
			deg_s10 <= pz_s9;
		end
	end

	assign push_item.pp = pp_s10;
	assign push_item.ee = ee_s10;
	assign push_item.up_p = up_s10;
	assign push_item.dv = dv_s10;
	assign push_item.deg = deg_s10;
	assign push_item.sd_pos = sd_pos_s10;

endmodule

FILE: design/vc2d_back.sv
// Back part: square roots, divides, arc cosine by CORDIC and output scaling,
// ending in the output register. Depends on vc2d_pkg.
module vc2d_back import vc2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fifo_stat_t  fifo_stat,
	input  fe_item_t    pop_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // screen_x [15:0], screen_y [31:16]
);

	localparam int SQA_N = 28;
	localparam int DIV_N = 33;
	localparam int SQB_N = 31;
	localparam int NB = (SQA_N + 1) + (DIV_N + 1) + 2 + (SQB_N + 1) + (CORDIC_N + 1) + 3;
	localparam logic [32:0] ONE30 = 33'd1 << 30;

	typedef struct packed {
		sq_step_t sp;
		sq_step_t se;
		logic signed [45:0] up_p;
		logic signed [41:0] dv;
		logic deg;
		logic sd_pos;
	} sqa_t;

	typedef struct packed {
		dv_step_t du;
		dv_step_t dd;
		logic [27:0] dsu;
		logic [27:0] dsd;
		logic up_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} dva_t;

	typedef struct packed {
		logic [30:0] cu_mag;
		logic [30:0] a;
		logic [61:0] sqc;
		logic [61:0] sqv;
		logic cu_neg;
		logic cv_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} cl_t;

	typedef struct packed {
		sq_step_t ss;
		sq_step_t sy;
		logic [30:0] cu_mag;
		logic [30:0] a;
		logic cu_neg;
		logic cv_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} sqb_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [25:0] z;
		logic [30:0] cu_mag;
		logic [30:0] su;
		logic cu_neg;
		logic cv_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} cr_t;

	typedef struct packed {
		logic [24:0] rad;
		logic [30:0] cu_mag;
		logic [30:0] su;
		logic cu_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} rd_t;

	typedef struct packed {
		logic [55:0] px;
		logic [55:0] py;
		logic cu_neg;
		logic dv_neg;
		logic deg;
		logic sd_pos;
	} ml_t;

	logic en;
	logic [NB-1:0] bv_q;

	sqa_t sqa_s [SQA_N+1];
	dva_t dva_s [DIV_N+1];
	cl_t c1_s;
	cl_t c2_s;
	sqb_t sqb_s [SQB_N+1];
	cr_t cr_s [CORDIC_N+1];
	rd_t r1_s;
	ml_t m1_s;
	logic [15:0] sx_q;
	logic [15:0] sy_q;

	logic [45:0] up_mag_c;
	logic [41:0] dv_mag_c;
	logic [60:0] nu_c;
	logic [60:0] nd_c;
	logic [30:0] qu_c;
	logic [30:0] qd_c;
	logic [24:0] zc_c;
	logic [55:0] mx_c;
	logic [55:0] my_c;

	function automatic logic [15:0] sat16(input logic [55:0] mag, input logic neg);
		logic [15:0] r;
		if (!neg)
			r = (mag > 56'd32767) ? 16'h7fff : mag[15:0];
		else
			r = (mag > 56'd32768) ? 16'h8000 : 16'(16'd0 - mag[15:0]);
		return r;
	endfunction

	assign en = !bv_q[NB-1] || m_tready;
	assign pop = en && !fifo_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q <= '0;
		end else if (en) begin
			bv_q <= {bv_q[NB-2:0], !fifo_stat.empty};
		end
	end

	always_comb begin
		up_mag_c = sqa_s[SQA_N].up_p[45] ? 46'(-sqa_s[SQA_N].up_p) : 46'(sqa_s[SQA_N].up_p);
		dv_mag_c = sqa_s[SQA_N].dv[41] ? 42'(-sqa_s[SQA_N].dv) : 42'(sqa_s[SQA_N].dv);
		nu_c = {up_mag_c[44:0], 16'd0};
		nd_c = {4'd0, dv_mag_c[40:0], 16'd0};
		qu_c = (dva_s[DIV_N].du.q > ONE30) ? ONE30[30:0] : dva_s[DIV_N].du.q[30:0];
		qd_c = (dva_s[DIV_N].dd.q > ONE30) ? ONE30[30:0] : dva_s[DIV_N].dd.q[30:0];
		if (cr_s[CORDIC_N].z < 26'sd0)
			zc_c = '0;
		else if (cr_s[CORDIC_N].z > 26'sd8388608)
			zc_c = 25'd8388608;
		else
			zc_c = 25'(cr_s[CORDIC_N].z);
		mx_c = m1_s.px >> OUT_SHIFT;
		my_c = m1_s.py >> OUT_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s[0].sp <= '{rem: '0, q: '0, x: {pop_item.pp, 8'd0}};
			sqa_s[0].se <= '{rem: '0, q: '0, x: {8'd0, pop_item.ee, 8'd0}};
			sqa_s[0].up_p <= pop_item.up_p;
			sqa_s[0].dv <= pop_item.dv;
			sqa_s[0].deg <= pop_item.deg;
			sqa_s[0].sd_pos <= pop_item.sd_pos;
			for (int k = 0; k < SQA_N; k++) begin
				sqa_s[k+1] <= '{sp: sq_step(sqa_s[k].sp), se: sq_step(sqa_s[k].se),
					up_p: sqa_s[k].up_p, dv: sqa_s[k].dv, deg: sqa_s[k].deg,
					sd_pos: sqa_s[k].sd_pos};
			end

			dva_s[0].du <= '{rem: nu_c[60:33], low: nu_c[32:0], q: '0};
			dva_s[0].dd <= '{rem: nd_c[60:33], low: nd_c[32:0], q: '0};
			dva_s[0].dsu <= sqa_s[SQA_N].sp.q[27:0];
			dva_s[0].dsd <= sqa_s[SQA_N].se.q[27:0];
			dva_s[0].up_neg <= sqa_s[SQA_N].up_p[45];
			dva_s[0].dv_neg <= sqa_s[SQA_N].dv[41];
			dva_s[0].deg <= sqa_s[SQA_N].deg;
			dva_s[0].sd_pos <= sqa_s[SQA_N].sd_pos;
			for (int k = 0; k < DIV_N; k++) begin
				dva_s[k+1] <= '{du: div_step(dva_s[k].du, dva_s[k].dsu),
					dd: div_step(dva_s[k].dd, dva_s[k].dsd),
					dsu: dva_s[k].dsu, dsd: dva_s[k].dsd,
					up_neg: dva_s[k].up_neg, dv_neg: dva_s[k].dv_neg,
					deg: dva_s[k].deg, sd_pos: dva_s[k].sd_pos};
			end

			c1_s.cu_mag <= qu_c;
			c1_s.a <= qd_c;
			c1_s.sqc <= '0;
			c1_s.sqv <= '0;
			c1_s.cu_neg <= dva_s[DIV_N].up_neg;
			c1_s.cv_neg <= dva_s[DIV_N].dv_neg && (qd_c != '0);
			c1_s.dv_neg <= dva_s[DIV_N].dv_neg;
			c1_s.deg <= dva_s[DIV_N].deg;
			c1_s.sd_pos <= dva_s[DIV_N].sd_pos;

			c2_s <= '{cu_mag: c1_s.cu_mag, a: c1_s.a,
				sqc: 62'(c1_s.cu_mag) * 62'(c1_s.cu_mag),
				sqv: 62'(c1_s.a) * 62'(c1_s.a),
				cu_neg: c1_s.cu_neg, cv_neg: c1_s.cv_neg, dv_neg: c1_s.dv_neg,
				deg: c1_s.deg, sd_pos: c1_s.sd_pos};

			sqb_s[0].ss <= '{rem: '0, q: '0, x: {62'((62'd1 << 60) - c2_s.sqc), 2'b00}};
			sqb_s[0].sy <= '{rem: '0, q: '0, x: {62'((62'd1 << 60) - c2_s.sqv), 2'b00}};
			sqb_s[0].cu_mag <= c2_s.cu_mag;
			sqb_s[0].a <= c2_s.a;
			sqb_s[0].cu_neg <= c2_s.cu_neg;
			sqb_s[0].cv_neg <= c2_s.cv_neg;
			sqb_s[0].dv_neg <= c2_s.dv_neg;
			sqb_s[0].deg <= c2_s.deg;
			sqb_s[0].sd_pos <= c2_s.sd_pos;
			for (int k = 0; k < SQB_N; k++) begin
				sqb_s[k+1] <= '{ss: sq_step(sqb_s[k].ss), sy: sq_step(sqb_s[k].sy),
					cu_mag: sqb_s[k].cu_mag, a: sqb_s[k].a,
					cu_neg: sqb_s[k].cu_neg, cv_neg: sqb_s[k].cv_neg,
					dv_neg: sqb_s[k].dv_neg, deg: sqb_s[k].deg,
					sd_pos: sqb_s[k].sd_pos};
			end

			cr_s[0].x <= 34'(sqb_s[SQB_N].a);
			cr_s[0].y <= 34'(sqb_s[SQB_N].sy.q[30:0]);
			cr_s[0].z <= '0;
			cr_s[0].cu_mag <= sqb_s[SQB_N].cu_mag;
			cr_s[0].su <= sqb_s[SQB_N].ss.q[30:0];
			cr_s[0].cu_neg <= sqb_s[SQB_N].cu_neg;
			cr_s[0].cv_neg <= sqb_s[SQB_N].cv_neg;
			cr_s[0].dv_neg <= sqb_s[SQB_N].dv_neg;
			cr_s[0].deg <= sqb_s[SQB_N].deg;
			cr_s[0].sd_pos <= sqb_s[SQB_N].sd_pos;
			for (int k = 0; k < CORDIC_N; k++) begin
				cr_s[k+1].cu_mag <= cr_s[k].cu_mag;
				cr_s[k+1].su <= cr_s[k].su;
				cr_s[k+1].cu_neg <= cr_s[k].cu_neg;
				cr_s[k+1].cv_neg <= cr_s[k].cv_neg;
				cr_s[k+1].dv_neg <= cr_s[k].dv_neg;
				cr_s[k+1].deg <= cr_s[k].deg;
				cr_s[k+1].sd_pos <= cr_s[k].sd_pos;
				if (cr_s[k].y > 34'sd0) begin
					cr_s[k+1].x <= cr_s[k].x + (cr_s[k].y >>> k);
					cr_s[k+1].y <= cr_s[k].y - (cr_s[k].x >>> k);
					cr_s[k+1].z <= cr_s[k].z + ATAN_TAB[k];
				end else begin
					cr_s[k+1].x <= cr_s[k].x - (cr_s[k].y >>> k);
					cr_s[k+1].y <= cr_s[k].y + (cr_s[k].x >>> k);
					cr_s[k+1].z <= cr_s[k].z - ATAN_TAB[k];
				end
			end

			r1_s.rad <= cr_s[CORDIC_N].cv_neg ? 25'(25'd16777216 - zc_c) : zc_c;
			r1_s.cu_mag <= cr_s[CORDIC_N].cu_mag;
			r1_s.su <= cr_s[CORDIC_N].su;
			r1_s.cu_neg <= cr_s[CORDIC_N].cu_neg;
			r1_s.dv_neg <= cr_s[CORDIC_N].dv_neg;
			r1_s.deg <= cr_s[CORDIC_N].deg;
			r1_s.sd_pos <= cr_s[CORDIC_N].sd_pos;

			m1_s.px <= 56'(r1_s.su) * 56'(r1_s.rad);
			m1_s.py <= 56'(r1_s.cu_mag) * 56'(r1_s.rad);
			m1_s.cu_neg <= r1_s.cu_neg;
			m1_s.dv_neg <= r1_s.dv_neg;
			m1_s.deg <= r1_s.deg;
			m1_s.sd_pos <= r1_s.sd_pos;

			if (m1_s.deg) begin
				sx_q <= '0;
				sy_q <= m1_s.dv_neg ? DEG_Y : 16'd0;
			end else begin
				sx_q <= sat16(mx_c, !m1_s.sd_pos);
				sy_q <= sat16(my_c, m1_s.cu_neg);
			end
		end
	end

	assign m_tvalid = bv_q[NB-1];
	assign m_tdata = {sy_q, sx_q};

endmodule

FILE: design/view_coordinates_2d.sv
// Throughput: one word per cycle; the front takes a word every cycle while the
// back flows, set by the fully pipelined square root, divide and CORDIC units.
// Reset: arst_n clears all valid bits and the queue pointers; data stays as is.
// Depends on vc2d_pkg, vc2d_front, vc2d_fifo, vc2d_back.
`include "view_coordinates_2d_defines.svh"
module view_coordinates_2d import vc2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// my_pos_x/y/z [95:0], view_dir_x/y/z [143:96], up_dir_x/y/z [191:144],
	// target_pos_x/y/z [287:192]
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata   // screen_x [15:0], screen_y [31:16]
);

	logic fifo_push;
	logic fifo_pop;
	fe_item_t push_item;
	fe_item_t pop_item;
	fifo_stat_t fifo_stat;

	vc2d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.fifo_stat (fifo_stat),
		.push      (fifo_push),
		.push_item (push_item)
	);

	vc2d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_item (push_item),
		.pop       (fifo_pop),
		.pop_item  (pop_item),
		.stat      (fifo_stat)
	);

	vc2d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.pop_item  (pop_item),
		.pop       (fifo_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`VC2D_ASSERT_IMP(a_push_room, fifo_push, !fifo_stat.full || fifo_pop, "queue overrun")
	`VC2D_ASSERT_IMP(a_pop_data, fifo_pop, !fifo_stat.empty, "queue underrun")
	`VC2D_ASSERT_NXT(a_push_lands, fifo_push && !fifo_pop, !fifo_stat.empty, "word lost")

endmodule

FILE: tb/sv/tb_view_coordinates_2d.sv
// Self-checking testbench for view_coordinates_2d: drives observer, view, up
// and target words on the input stream and checks radar coordinates against
// an in-bench fixed-point predictor. Depends on vc2d_pkg and the design.
`timescale 1ns / 100ps
module tb_view_coordinates_2d;
	import vc2d_pkg::*;

	localparam int N_RANDOM = 1030;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam int LATENCY = 135;
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

	typedef struct {
		logic signed [31:0] me [3];
		logic signed [15:0] vw [3];
		logic signed [15:0] up [3];
		logic signed [31:0] tg [3];
	} scene_t;

	typedef struct {
		scene_t sc;
		bit has_exp;
		logic [15:0] ex, ey;
	} case_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [287:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;

	logic [31:0] coord_q[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_req = 1'b0;
	bit hold_off = 1'b0;
	bit feeding_done = 1'b0;
	case_row_t rows[$];

	view_coordinates_2d u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clip30(longint v);
		longint one;
		one = 64'sd1 << 30;
		return v > one ? one : (v < -one ? -one : v);
	endfunction

	function automatic longint acos_half_turns(longint c);
		bit neg;
		longint a, x, y, z, nx;
		neg = c < 0;
		a = neg ? -c : c;
		x = a;
		y = longint'(int_sqrt((64'd1 << 60) - longint'(a) * longint'(a)));
		z = 0;
		for (int i = 0; i < CORDIC_N; i++) begin
			if (y > 0) begin
				nx = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(ATAN_TAB[i]);
			end else begin
				nx = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		if (z < 0) z = 0;
		if (z > (64'sd1 << 23)) z = 64'sd1 << 23;
		return neg ? (64'sd1 << 24) - z : z;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint scale_by_radius(longint v30, longint rad);
		longint unsigned mag;
		longint r;
		mag = v30 < 0 ? -v30 : v30;
		r = longint'((mag * longint'(rad)) >> OUT_SHIFT);
		return v30 < 0 ? -r : r;
	endfunction

	function automatic logic [31:0] radar_coords(scene_t s);
		longint v[3], u[3], d[3], e[3], p[3], rv[3];
		longint dv, up_p, sd, cu, cv, su, rad, xs;
		longint unsigned mag, pp, ee, plen, elen, a;
		int rs, ls;
		dv = 0; up_p = 0; sd = 0; mag = 0; pp = 0; ee = 0; rs = 0; ls = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = s.vw[i];
			u[i] = s.up[i];
			d[i] = longint'(s.tg[i]) - longint'(s.me[i]);
			a = d[i] < 0 ? -d[i] : d[i];
			if (a > mag) mag = a;
		end
		if (mag != 0) begin
			while ((mag >> rs) >= (64'd1 << 23)) rs++;
			while ((mag << ls) < (64'd1 << 22)) ls++;
		end
		for (int i = 0; i < 3; i++) begin
			e[i] = rs != 0 ? floor_shr(d[i], rs) : d[i] <<< ls;
			dv += v[i] * e[i];
		end
		for (int i = 0; i < 3; i++) begin
			p[i] = e[i] - floor_shr(dv * v[i], 28);
			pp += p[i] * p[i];
			ee += e[i] * e[i];
			up_p += u[i] * p[i];
		end
		if (pp == 0) return {dv >= 0 ? 16'd0 : DEG_Y, 16'd0};
		elen = int_sqrt(ee);
		if (elen == 0) return '0;
		plen = int_sqrt(pp);
		cu = clip30((up_p * 65536) / longint'(plen));
		su = longint'(int_sqrt((64'd1 << 60) - cu * cu));
		cv = clip30((dv * 65536) / longint'(elen));
		rad = acos_half_turns(cv);
		rv[0] = v[1] * u[2] - v[2] * u[1];
		rv[1] = v[2] * u[0] - v[0] * u[2];
		rv[2] = v[0] * u[1] - v[1] * u[0];
		for (int i = 0; i < 3; i++) sd += rv[i] * e[i];
		xs = scale_by_radius(su, rad);
		return {clip16(scale_by_radius(cu, rad)), clip16(sd > 0 ? xs : -xs)};
	endfunction

	function automatic logic [287:0] pack_scene(scene_t s);
		return {s.tg[2], s.tg[1], s.tg[0], s.up[2], s.up[1], s.up[0],
			s.vw[2], s.vw[1], s.vw[0], s.me[2], s.me[1], s.me[0]};
	endfunction

	function automatic logic signed [15:0] rand_dir_comp();
		return 16'(int'($urandom_range(32768)) - 16384);
	endfunction

	// mostly unit axes and near-unit vectors, rest raw component noise
	function automatic scene_t random_scene();
		scene_t s;
		int k, ax, ax2;
		k = $urandom_range(9);
		ax = $urandom_range(2);
		ax2 = (ax + 1 + $urandom_range(1)) % 3;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(3))
				0: s.me[i] = $urandom;
				1: s.me[i] = 32'(int'($urandom_range(2000000)) - 1000000);
				default: s.me[i] = 32'(int'($urandom_range(131072)) - 65536);
			endcase
			s.tg[i] = ($urandom_range(3) == 0) ? $urandom :
				s.me[i] + 32'(int'($urandom_range(4000000)) - 2000000);
			if (k < 6) begin
				s.vw[i] = (i == ax) ? ($urandom_range(1) ? ONE_Q14 : -ONE_Q14) : 16'sd0;
				s.up[i] = (i == ax2) ? ($urandom_range(1) ? ONE_Q14 : -ONE_Q14) : 16'sd0;
			end else if (k < 8) begin
				s.vw[i] = (i == ax) ? 16'sd16000 : 16'(int'($urandom_range(6000)) - 3000);
				s.up[i] = (i == ax2) ? 16'sd16000 : 16'(int'($urandom_range(6000)) - 3000);
			end else begin
				s.vw[i] = rand_dir_comp();
				s.up[i] = rand_dir_comp();
			end
		end
		if ($urandom_range(15) == 0) s.tg = s.me;
		return s;
	endfunction

	function automatic scene_t make_scene(int mx, int my, int mz, int vx, int vy, int vz,
		int ux, int uy, int uz, int tx, int ty, int tz);
		scene_t s;
		s.me = '{32'(mx), 32'(my), 32'(mz)};
		s.vw = '{16'(vx), 16'(vy), 16'(vz)};
		s.up = '{16'(ux), 16'(uy), 16'(uz)};
		s.tg = '{32'(tx), 32'(ty), 32'(tz)};
		return s;
	endfunction

	task automatic add_row(scene_t s, bit known, logic [15:0] x, logic [15:0] y);
		case_row_t r;
		r.sc = s; r.has_exp = known; r.ex = x; r.ey = y;
		rows.push_back(r);
	endtask

	task automatic send_scene(scene_t s, bit known, logic [15:0] x, logic [15:0] y);
		logic [31:0] pred;
		pred = radar_coords(s);
		if (known && pred !== {y, x}) begin
			$display("%0t predictor row mismatch exp %h act %h", $time, {y, x}, pred);
			errors++;
		end
		if ($urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(9) == 0 ? $urandom_range(40, 1) : $urandom_range(3, 1))
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_scene(s);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		coord_q.push_back(pred);
	endtask

	initial begin
		scene_t s;
		// zero offset, target ahead, target behind, pure side, pure up, extremes
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, 0, 0), 1, 16'd0, 16'd0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 65536, 0, 0), 1, 16'd0,
			16'd0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, -65536, 0, 0), 1, 16'd0,
			DEG_Y);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, 0, 65536), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, 65536, 0), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 0, -65536, 0), 0, 0, 0);
		add_row(make_scene(0, 0, 0, -16384, 0, 0, 0, 0, -16384, 0, 0, -65536), 0, 0, 0);
		add_row(make_scene(-2147483648, -2147483648, -2147483648, 0, 16384, 0, 16384, 0, 0,
			2147483647, 2147483647, 2147483647), 0, 0, 0);
		add_row(make_scene(2147483647, 2147483647, 2147483647, 0, 0, 16384, 0, 16384, 0,
			-2147483648, -2147483648, -2147483648), 0, 0, 0);
		add_row(make_scene(2147483647, 0, -2147483648, -16384, -16384, -16384, 16384, 16384,
			16384, -2147483648, 1, 2147483647), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 0, 0, 0, 0, 0, 0, 3, -1, 7), 0, 0, 0);
		add_row(make_scene(5, 5, 5, 0, 16384, 0, 0, 0, 16384, 5, 5, 5), 1, 16'd0, 16'd0);
		add_row(make_scene(0, 0, 0, 11585, 11585, 0, 0, 0, 16384, 1000, 1000, 0), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, 1, -1), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 100, 0, 100), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 0, 16384, 100, -100, 0), 0, 0, 0);
		add_row(make_scene(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 0, 0, 0), 1, 16'd0, 16'd0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_scene(rows[i].sc, rows[i].has_exp, rows[i].ex, rows[i].ey);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == 300) hold_req = 1'b1;
			s = random_scene();
			send_scene(s, 0, 0, 0);
		end
		s_tvalid <= 1'b0;
		feeding_done = 1'b1;
	end

	// long receiver hold-off so the pipeline backs up into s_tready
	initial begin
		wait (hold_req);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off && cycles % 500 != 499) m_tready <= 1'b0;
			else if ($urandom_range(3) == 0)
				m_tready <= ($urandom_range(9) == 0) ? 1'b0 : 1'($urandom_range(1));
			else m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (coord_q.size() == 0) begin
				$display("%0t unexpected word act %h", $time, m_tdata);
				errors++;
			end else begin
				want = coord_q.pop_front();
				if (m_tdata[15:0] !== want[15:0]) begin
					$display("%0t screen_x exp %h act %h", $time, want[15:0], m_tdata[15:0]);
					errors++;
				end
				if (m_tdata[31:16] !== want[31:16]) begin
					$display("%0t screen_y exp %h act %h", $time, want[31:16],
						m_tdata[31:16]);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (feeding_done);
		while (coord_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && coord_q.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

FILE: filelist.f
+incdir+design
design/vc2d_pkg.sv
design/vc2d_fifo.sv
design/vc2d_front.sv
design/vc2d_back.sv
design/view_coordinates_2d.sv
tb/sv/tb_view_coordinates_2d.sv
